// ----- hw/rtl/life_generation_step_defines.svh -----
// ----------------------------------------------------------------------------
// life_generation_step_defines.svh
// Assertion macros shared by the Life generation step RTL.
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_STEP_DEFINES_SVH
`define LIFE_GENERATION_STEP_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on clk, off while rst is high
`define LGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on clk at every edge, reset included
`define LGS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LGS_ASSERT(lbl, prop, msg)
`define LGS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- hw/rtl/lgs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants and types of the Life generation step block.
// ----------------------------------------------------------------------------
package lgs_pkg;

  // Row word and index widths
  localparam int WORD_W      = 32;
  localparam int IDX_W       = 5;
  localparam int CNT_W       = 6;
  localparam int STORE_DEPTH = 32;

  // Grid size limits and reset values
  localparam int MIN_SIZE     = 3;
  localparam int ROWS_RESET   = 20;
  localparam int COLS_RESET   = 20;
  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 32;

  // Config port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Grid memory access
  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
  } mem_req_t;

endpackage

// ----- hw/rtl/lgs_grid_mem.sv -----
// ----------------------------------------------------------------------------
// lgs_grid_mem
// Grid row store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lgs_grid_mem #(
  parameter int DEPTH = lgs_pkg::STORE_DEPTH
) (
  input  logic                      clk,
  input  lgs_pkg::mem_req_t         req,
  output logic [lgs_pkg::WORD_W-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [lgs_pkg::WORD_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[AW-1:0]];
    end
  end

endmodule

// ----- hw/rtl/lgs_row_eval.sv -----
// ----------------------------------------------------------------------------
// lgs_row_eval
// Next-generation row from three rows, wrapping at the active column count.
// ----------------------------------------------------------------------------
module lgs_row_eval (
  input  logic [lgs_pkg::WORD_W-1:0] up,
  input  logic [lgs_pkg::WORD_W-1:0] mid,
  input  logic [lgs_pkg::WORD_W-1:0] dn,
  input  logic [lgs_pkg::CNT_W-1:0]  nc,
  output logic [lgs_pkg::WORD_W-1:0] next_row
);

  localparam int W = lgs_pkg::WORD_W;

  logic [lgs_pkg::CNT_W-1:0] nc_m1_w;
  logic [lgs_pkg::IDX_W-1:0] last_col;

  assign nc_m1_w  = nc - lgs_pkg::CNT_W'(1);
  assign last_col = nc_m1_w[lgs_pkg::IDX_W-1:0];

  // Per column: gather eight neighbors with horizontal wrap, apply the rule
  for (genvar c = 0; c < W; c++) begin : g_col
    localparam int CL = (c + W - 1) % W;
    localparam int CR = (c + 1) % W;

    logic       at_first;
    logic       at_last;
    logic       up_l, up_r, mid_l, mid_r, dn_l, dn_r;
    logic [3:0] cnt;

    assign at_first = (c == 0);
    assign at_last  = (last_col == lgs_pkg::IDX_W'(c));

    assign up_l  = at_first ? up[last_col]  : up[CL];
    assign mid_l = at_first ? mid[last_col] : mid[CL];
    assign dn_l  = at_first ? dn[last_col]  : dn[CL];
    assign up_r  = at_last  ? up[0]  : up[CR];
    assign mid_r = at_last  ? mid[0] : mid[CR];
    assign dn_r  = at_last  ? dn[0]  : dn[CR];

    assign cnt = 4'(up_l) + 4'(up[c]) + 4'(up_r) + 4'(mid_l) + 4'(mid_r)
               + 4'(dn_l) + 4'(dn[c]) + 4'(dn_r);

    // Born on three, survives on two or three; columns past nc stay dead
    assign next_row[c] = (lgs_pkg::CNT_W'(c) < nc) &&
                         ((cnt == 4'd3) || (mid[c] && (cnt == 4'd2)));
  end

endmodule

// ----- hw/rtl/life_generation_step.sv -----
// ----------------------------------------------------------------------------
// life_generation_step
// Stores grid rows as they arrive, then computes one Life generation on a
// torus and sends out the new rows in order.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | word
//  ---------+-------------------------------------------+----------------------
//  input    | row_valid, row_ready, row_cells           | one grid row
//  result   | res_valid, res_ready, next_cells,         | one new row
//           | row_number, last_row                      |
//  config   | psel, penable, pwrite, paddr, pwdata,     | rows_used @0,
//           | prdata, pready                            | cols_used @4
//
// Rows are written to the row store as they are accepted. After the last row
// of a generation, the grid memory's single read port is walked over nr+2 rows
// (nr = rows in use), one read per cycle, and one result row leaves per cycle
// from the third read on; row_ready comes back when the last result row is
// loaded into the result register.
// Reset clears the control state and sets the config registers to their reset
// values; the row store is not cleared. A low res_ready holds the read walk in place.
// ----------------------------------------------------------------------------
`include "life_generation_step_defines.svh"

module life_generation_step #(
  parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Row input
  input  logic                        row_valid,
  output logic                        row_ready,
  input  logic [lgs_pkg::WORD_W-1:0]  row_cells,
  // Result output
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [lgs_pkg::WORD_W-1:0]  next_cells,
  output logic [lgs_pkg::IDX_W-1:0]   row_number,
  output logic                        last_row,
  // Config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lgs_pkg::PADDR_W-1:0] paddr,
  input  logic [lgs_pkg::PDATA_W-1:0] pwdata,
  output logic [lgs_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int ROW_LIM = (MAX_ROWS < lgs_pkg::STORE_DEPTH) ? MAX_ROWS
                                                             : lgs_pkg::STORE_DEPTH;
  localparam int COL_LIM = (MAX_COLS < lgs_pkg::WORD_W) ? MAX_COLS : lgs_pkg::WORD_W;
  localparam int CW      = lgs_pkg::CNT_W;
  localparam int W       = lgs_pkg::WORD_W;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t                    state;
  logic [CW-1:0]             rows_used;
  logic [CW-1:0]             cols_used;
  logic [lgs_pkg::IDX_W-1:0] load_cnt;
  logic [CW-1:0]             iss_step;
  logic [CW-1:0]             con_step;
  logic                      pend;
  logic [W-1:0]              win_up;
  logic [W-1:0]              win_mid;

  logic [CW-1:0]     nr;
  logic [CW-1:0]     nc;
  logic [W-1:0]      colmask;
  logic              cfg_wr;
  logic              row_acc;
  logic              gen_done;
  logic              issue;
  logic              consume;
  logic              out_free;
  logic              out_load;
  logic              last_step;
  logic [CW-1:0]     rd_addr_w;
  logic [CW-1:0]     row_num_w;
  logic [W-1:0]      rd_data;
  logic [W-1:0]      eval_row;
  lgs_pkg::mem_req_t mem_req;

  // Config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == lgs_pkg::REG_COLS) ? lgs_pkg::PDATA_W'(cols_used)
                                                  : lgs_pkg::PDATA_W'(rows_used);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used <= CW'(lgs_pkg::ROWS_RESET);
      cols_used <= CW'(lgs_pkg::COLS_RESET);
    end else if (cfg_wr) begin
      case (paddr[2])
        lgs_pkg::REG_ROWS: rows_used <= pwdata[CW-1:0];
        lgs_pkg::REG_COLS: cols_used <= pwdata[CW-1:0];
        default:           rows_used <= rows_used;
      endcase
    end
  end

  // Effective grid size
  always_comb begin
    if (rows_used < CW'(lgs_pkg::MIN_SIZE)) begin
      nr = CW'(lgs_pkg::MIN_SIZE);
    end else if (rows_used > CW'(ROW_LIM)) begin
      nr = CW'(ROW_LIM);
    end else begin
      nr = rows_used;
    end
    if (cols_used < CW'(lgs_pkg::MIN_SIZE)) begin
      nc = CW'(lgs_pkg::MIN_SIZE);
    end else if (cols_used > CW'(COL_LIM)) begin
      nc = CW'(COL_LIM);
    end else begin
      nc = cols_used;
    end
  end

  for (genvar c = 0; c < W; c++) begin : g_mask
    assign colmask[c] = (CW'(c) < nc);
  end

  // Load side
  assign row_ready = (state == ST_LOAD);
  assign row_acc   = row_valid && row_ready;
  assign gen_done  = (CW'(load_cnt) + CW'(1)) >= nr;

  // Read walk: rows nr-1, 0, 1, ..., nr-1, 0; one read in flight at most
  assign out_free  = !res_valid || res_ready;
  assign last_step = (con_step == nr + CW'(1));
  assign consume   = pend && ((con_step < CW'(2)) || out_free);
  assign out_load  = consume && (con_step >= CW'(2));
  assign issue     = (state == ST_EMIT) && (iss_step <= nr + CW'(1)) &&
                     (!pend || consume);

  always_comb begin
    if (iss_step == '0) begin
      rd_addr_w = nr - CW'(1);
    end else if (iss_step == nr + CW'(1)) begin
      rd_addr_w = '0;
    end else begin
      rd_addr_w = iss_step - CW'(1);
    end
  end

  always_comb begin
    mem_req.wr_en   = row_acc;
    mem_req.wr_addr = load_cnt;
    mem_req.wr_data = row_cells & colmask;
    mem_req.rd_en   = issue;
    mem_req.rd_addr = rd_addr_w[lgs_pkg::IDX_W-1:0];
  end

  lgs_grid_mem #(
    .DEPTH (ROW_LIM)
  ) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Window of rows above and at the center; read data is the row below
  lgs_row_eval u_eval (
    .up       (win_up),
    .mid      (win_mid),
    .dn       (rd_data),
    .nc       (nc),
    .next_row (eval_row)
  );

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      load_cnt <= '0;
      iss_step <= '0;
      con_step <= '0;
      pend     <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (row_acc) begin
            if (gen_done) begin
              load_cnt <= '0;
              state    <= ST_EMIT;
            end else begin
              load_cnt <= load_cnt + lgs_pkg::IDX_W'(1);
            end
          end
        end
        ST_EMIT: begin
          if (issue) begin
            iss_step <= iss_step + CW'(1);
            pend     <= 1'b1;
          end else if (consume) begin
            pend <= 1'b0;
          end
          if (consume) begin
            con_step <= con_step + CW'(1);
          end
          if (out_load && last_step) begin
            iss_step <= '0;
            con_step <= '0;
            pend     <= 1'b0;
            state    <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // Row window
  always_ff @(posedge clk) begin
    if (consume) begin
      win_up  <= win_mid;
      win_mid <= rd_data;
    end
  end

  // Result register
  assign row_num_w = con_step - CW'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      next_cells <= eval_row & colmask;
      row_number <= row_num_w[lgs_pkg::IDX_W-1:0];
      last_row   <= last_step;
    end
  end

  // Checks
  `LGS_ASSERT(a_no_rw_overlap, !(mem_req.wr_en && mem_req.rd_en), "grid read and write overlap")
  `LGS_ASSERT(a_walk_in_step, iss_step == con_step + CW'(pend), "read walk out of step")
  `LGS_ASSERT(a_load_in_range, CW'(load_cnt) < CW'(ROW_LIM), "load index past store")
  `LGS_ASSERT(a_last_ends_gen, (out_load && last_step) |=> (state == ST_LOAD && !pend), "generation did not end")

endmodule
